>>> sv/binary_tree_traversal_engine_assert.svh
// assertion macros used by the checker file
`ifndef BINARY_TREE_TRAVERSAL_ENGINE_ASSERT_SVH
`define BINARY_TREE_TRAVERSAL_ENGINE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BTE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bte_pkg.sv
package bte_pkg;

	// default tree capacity
	localparam int DEF_MAX_NODES = 16;

	// stream word widths
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 8;
	localparam int M_USER_W = 3;

	// walk order codes
	typedef enum logic [1:0] {
		WALK_PRE  = 2'd0,
		WALK_IN   = 2'd1,
		WALK_POST = 2'd2
	} walk_t;

endpackage

>>> sv/binary_tree_traversal_engine.sv
// Non-final node records are taken one per cycle, back to back, written at once.
// The final record starts the walks: a scan over the ids finds each root, and every
// emitted word follows registered reads of the child and stack memories; an output stall holds the walk.
// Each word waits in a pending register until the next is emitted or the run ends;
// results stop at 3*MAX_NODES. Async reset (arst_n low) clears control, parent marks and
// node count; child tables and stack hold no reset value.
module binary_tree_traversal_engine
	import bte_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// node_index [3:0], left_child [8:4], right_child [13:9], zero pad [15:14]
	input  logic [S_DATA_W-1:0] s_tdata,
	// final_record
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// visited_node [3:0], zero pad [7:4]
	output logic [M_DATA_W-1:0] m_tdata,
	// end_of_walk
	output logic                m_tlast,
	// walk_order [1:0], end_of_all [2]
	output logic [M_USER_W-1:0] m_tuser
);

	localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int SP_W    = $clog2(MAX_NODES + 1);
	localparam int MAX_OUT = 3 * MAX_NODES;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);

	typedef enum logic [16:0] {
		S_IDLE   = 17'd1,
		S_SCAN   = 17'd2,
		S_P_POP  = 17'd4,
		S_P_NODE = 17'd8,
		S_P_KIDR = 17'd16,
		S_P_KIDL = 17'd32,
		S_I_PUSH = 17'd64,
		S_I_LEFT = 17'd128,
		S_I_POP  = 17'd256,
		S_I_EMIT = 17'd512,
		S_I_RGT  = 17'd1024,
		S_Q_PUSH = 17'd2048,
		S_Q_LEFT = 17'd4096,
		S_Q_CHK  = 17'd8192,
		S_Q_TOP  = 17'd16384,
		S_Q_DEC  = 17'd32768,
		S_FLUSH  = 17'd65536
	} state_t;

	// child link decode: {valid, id}
	function automatic logic [NODE_W:0] child_of(input logic [4:0] raw);
		logic ok;
		ok = !raw[4] && (32'(raw) < MAX_NODES);
		return {ok, NODE_W'(raw[3:0])};
	endfunction

	state_t              state_q, state_d;
	logic [SP_W-1:0]     sp_q, sp_d, sp_m1;
	logic [SP_W-1:0]     scan_q, scan_d;
	logic [SP_W-1:0]     cnt_q;
	logic [CNT_W-1:0]    res_cnt_q, res_cnt_d;
	logic [NODE_W-1:0]   root_q, root_d;
	logic [NODE_W-1:0]   cur_q, cur_d;
	logic                cur_ok_q, cur_ok_d;
	logic [NODE_W-1:0]   last_q, last_d;
	logic                last_ok_q, last_ok_d;
	logic [MAX_NODES-1:0] has_parent_q;
	logic [MAX_NODES-1:0] par_set;

	// memories and their registered read data
	logic [9:0]          ch_mem [MAX_NODES];
	logic [9:0]          ch_rd_q;
	logic [NODE_W-1:0]   stk_mem [MAX_NODES];
	logic [NODE_W-1:0]   stk_rd_q;

	logic                ch_re, st_we, st_re;
	logic [NODE_W-1:0]   ch_raddr, st_waddr, st_wdata, st_raddr;

	// emission control
	logic                emit, emit_ok, slot_free, mark_eow, flush_go, clear_run;
	walk_t               emit_ord;
	logic [NODE_W-1:0]   emit_node;
	logic                pend_v_q, pend_eow_q;
	walk_t               pend_ord_q;
	logic [3:0]          pend_node_q;
	logic [3:0]          out_node_q;
	walk_t               out_ord_q;
	logic                out_eow_q, out_eoa_q, out_v_q;

	// input record decode
	logic                acc, idx_ok;
	logic [3:0]          in_idx;
	logic [4:0]          in_left, in_right;
	logic [NODE_W:0]     in_lc, in_rc;
	logic [NODE_W:0]     rd_l, rd_r;
	logic                sp_full, sp_empty, cap;

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign in_idx   = s_tdata[3:0];
	assign in_left  = s_tdata[8:4];
	assign in_right = s_tdata[13:9];
	assign idx_ok   = 32'(in_idx) < MAX_NODES;
	assign in_lc    = child_of(in_left);
	assign in_rc    = child_of(in_right);
	assign rd_l     = child_of(ch_rd_q[9:5]);
	assign rd_r     = child_of(ch_rd_q[4:0]);

	assign sp_m1    = sp_q - 1'b1;
	assign sp_full  = (sp_q == SP_W'(MAX_NODES));
	assign sp_empty = (sp_q == '0);
	assign cap      = (res_cnt_q == CNT_W'(MAX_OUT));

	assign slot_free = !out_v_q || m_tready;
	assign emit_ok   = !pend_v_q || slot_free;

	// walk sequencer
	always_comb begin
		state_d   = state_q;
		sp_d      = sp_q;
		scan_d    = scan_q;
		res_cnt_d = res_cnt_q;
		root_d    = root_q;
		cur_d     = cur_q;
		cur_ok_d  = cur_ok_q;
		last_d    = last_q;
		last_ok_d = last_ok_q;
		ch_re     = 1'b0;
		ch_raddr  = stk_rd_q;
		st_we     = 1'b0;
		st_waddr  = sp_q[NODE_W-1:0];
		st_wdata  = cur_q;
		st_re     = 1'b0;
		st_raddr  = sp_m1[NODE_W-1:0];
		emit      = 1'b0;
		emit_ord  = WALK_PRE;
		emit_node = stk_rd_q;
		mark_eow  = 1'b0;
		flush_go  = 1'b0;
		clear_run = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc && s_tlast) begin
					scan_d    = '0;
					res_cnt_d = '0;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_q < cnt_q) begin
					if (!has_parent_q[scan_q[NODE_W-1:0]]) begin
						// root found: preorder starts with the root on the stack
						root_d   = scan_q[NODE_W-1:0];
						st_we    = 1'b1;
						st_waddr = '0;
						st_wdata = scan_q[NODE_W-1:0];
						sp_d     = SP_W'(1);
						state_d  = S_P_POP;
					end else begin
						scan_d = scan_q + 1'b1;
					end
				end else begin
					state_d = S_FLUSH;
				end
			end
			// preorder
			S_P_POP: begin
				if (sp_empty || cap) begin
					mark_eow = 1'b1;
					sp_d     = '0;
					cur_d    = root_q;
					cur_ok_d = 1'b1;
					state_d  = cap ? S_FLUSH : S_I_PUSH;
				end else begin
					st_re   = 1'b1;
					sp_d    = sp_m1;
					state_d = S_P_NODE;
				end
			end
			S_P_NODE: begin
				if (emit_ok) begin
					emit      = 1'b1;
					res_cnt_d = res_cnt_q + 1'b1;
					ch_re     = 1'b1;
					state_d   = S_P_KIDR;
				end
			end
			S_P_KIDR: begin
				if (rd_r[NODE_W] && !sp_full) begin
					st_we    = 1'b1;
					st_wdata = rd_r[NODE_W-1:0];
					sp_d     = sp_q + 1'b1;
				end
				state_d = S_P_KIDL;
			end
			S_P_KIDL: begin
				if (rd_l[NODE_W] && !sp_full) begin
					st_we    = 1'b1;
					st_wdata = rd_l[NODE_W-1:0];
					sp_d     = sp_q + 1'b1;
				end
				state_d = S_P_POP;
			end
			// inorder
			S_I_PUSH: begin
				if (cur_ok_q && !sp_full) begin
					st_we    = 1'b1;
					sp_d     = sp_q + 1'b1;
					ch_re    = 1'b1;
					ch_raddr = cur_q;
					state_d  = S_I_LEFT;
				end else begin
					state_d = S_I_POP;
				end
			end
			S_I_LEFT: begin
				cur_d    = rd_l[NODE_W-1:0];
				cur_ok_d = rd_l[NODE_W];
				state_d  = S_I_PUSH;
			end
			S_I_POP: begin
				if (sp_empty || cap) begin
					mark_eow  = 1'b1;
					sp_d      = '0;
					cur_d     = root_q;
					cur_ok_d  = 1'b1;
					last_ok_d = 1'b0;
					state_d   = cap ? S_FLUSH : S_Q_PUSH;
				end else begin
					st_re   = 1'b1;
					sp_d    = sp_m1;
					state_d = S_I_EMIT;
				end
			end
			S_I_EMIT: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_ord  = WALK_IN;
					res_cnt_d = res_cnt_q + 1'b1;
					ch_re     = 1'b1;
					state_d   = S_I_RGT;
				end
			end
			S_I_RGT: begin
				cur_d    = rd_r[NODE_W-1:0];
				cur_ok_d = rd_r[NODE_W];
				state_d  = S_I_PUSH;
			end
			// postorder
			S_Q_PUSH: begin
				if (cur_ok_q && !sp_full) begin
					st_we    = 1'b1;
					sp_d     = sp_q + 1'b1;
					ch_re    = 1'b1;
					ch_raddr = cur_q;
					state_d  = S_Q_LEFT;
				end else begin
					cur_ok_d = 1'b0;
					state_d  = S_Q_CHK;
				end
			end
			S_Q_LEFT: begin
				cur_d    = rd_l[NODE_W-1:0];
				cur_ok_d = rd_l[NODE_W];
				state_d  = S_Q_PUSH;
			end
			S_Q_CHK: begin
				if (sp_empty || cap) begin
					mark_eow = 1'b1;
					scan_d   = scan_q + 1'b1;
					state_d  = cap ? S_FLUSH : S_SCAN;
				end else begin
					// peek the top without popping
					st_re   = 1'b1;
					state_d = S_Q_TOP;
				end
			end
			S_Q_TOP: begin
				ch_re   = 1'b1;
				state_d = S_Q_DEC;
			end
			S_Q_DEC: begin
				if (rd_r[NODE_W] && !(last_ok_q && rd_r[NODE_W-1:0] == last_q) && !sp_full) begin
					cur_d    = rd_r[NODE_W-1:0];
					cur_ok_d = 1'b1;
					state_d  = S_Q_PUSH;
				end else if (emit_ok) begin
					emit      = 1'b1;
					emit_ord  = WALK_POST;
					res_cnt_d = res_cnt_q + 1'b1;
					last_d    = stk_rd_q;
					last_ok_d = 1'b1;
					sp_d      = sp_m1;
					state_d   = S_Q_CHK;
				end
			end
			S_FLUSH: begin
				// last word of the run goes out with both end marks
				if (!pend_v_q) begin
					clear_run = 1'b1;
					state_d   = S_IDLE;
				end else if (slot_free) begin
					flush_go  = 1'b1;
					clear_run = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			scan_q    <= '0;
			res_cnt_q <= '0;
			cur_ok_q  <= 1'b0;
			last_ok_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			sp_q      <= sp_d;
			scan_q    <= scan_d;
			res_cnt_q <= res_cnt_d;
			cur_ok_q  <= cur_ok_d;
			last_ok_q <= last_ok_d;
		end
	end

	// walk payload registers
	always_ff @(posedge clk) begin
		root_q <= root_d;
		cur_q  <= cur_d;
		last_q <= last_d;
	end

	// parent marks set by one record
	always_comb begin
		par_set = '0;
		if (idx_ok) begin
			if (in_lc[NODE_W]) par_set[in_lc[NODE_W-1:0]] = 1'b1;
			if (in_rc[NODE_W]) par_set[in_rc[NODE_W-1:0]] = 1'b1;
		end
	end

	// parent marks and record count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_parent_q <= '0;
			cnt_q        <= '0;
		end else if (clear_run) begin
			has_parent_q <= '0;
			cnt_q        <= '0;
		end else if (acc) begin
			has_parent_q <= has_parent_q | par_set;
			if (cnt_q != SP_W'(MAX_NODES)) cnt_q <= cnt_q + 1'b1;
		end
	end

	// child table memory, one write and one read port
	always_ff @(posedge clk) begin
		if (acc && idx_ok) ch_mem[NODE_W'(in_idx)] <= {in_left, in_right};
		if (ch_re) ch_rd_q <= ch_mem[ch_raddr];
	end

	// walk stack memory
	always_ff @(posedge clk) begin
		if (st_we) stk_mem[st_waddr] <= st_wdata;
		if (st_re) stk_rd_q <= stk_mem[st_raddr];
	end

	// pending word waits until the next one shows whether it ends a walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (emit) begin
			pend_v_q <= 1'b1;
		end else if (flush_go) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_ord_q  <= emit_ord;
			pend_node_q <= 4'(emit_node);
			pend_eow_q  <= 1'b0;
		end else if (mark_eow) begin
			pend_eow_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((emit && pend_v_q) || flush_go) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((emit && pend_v_q) || flush_go) begin
			out_node_q <= pend_node_q;
			out_ord_q  <= pend_ord_q;
			out_eow_q  <= pend_eow_q || flush_go;
			out_eoa_q  <= flush_go;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(M_DATA_W - 4){1'b0}}, out_node_q};
	assign m_tlast  = out_eow_q;
	assign m_tuser  = {out_eoa_q, out_ord_q};

endmodule

>>> sv/bte_checker.sv
`include "binary_tree_traversal_engine_assert.svh"

module bte_checker
	import bte_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                s_tlast,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast,
	input logic [M_USER_W-1:0] m_tuser
);

	// end of run always closes a walk
	`BTE_ASSERT_SAME(a_eoa_last, clk, arst_n, m_tvalid && m_tuser[2], m_tlast, "end_of_all without end_of_walk")

	// only the three walk codes appear
	`BTE_ASSERT_SAME(a_walk_code, clk, arst_n, m_tvalid, m_tuser[1:0] == WALK_PRE || m_tuser[1:0] == WALK_IN || m_tuser[1:0] == WALK_POST, "bad walk order code")

	// final record stops the input while the walks run
	`BTE_ASSERT_NEXT(a_final_stall, clk, arst_n, s_tvalid && s_tready && s_tlast, !s_tready, "input ready right after final record")

	// stalled output word holds
	`BTE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output word changed")

endmodule

bind binary_tree_traversal_engine bte_checker u_bte_checker (.*);
